@@ hdl/md5he_pkg.sv @@
`default_nettype none
package md5he_pkg;

	// initial chaining vector
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LAST_POS = 6'h3f;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// one queued item
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	// back-end sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	// which block is being compressed
	typedef enum logic [1:0] {
		PAD_NONE,
		PAD_FIRST,
		PAD_SECOND
	} pad_t;

	// round constant table
	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// rotate amount per round
	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	// message word index per round
	function automatic logic [3:0] word_sel(input logic [5:0] i);
		logic [8:0] t;
		case (i[5:4])
			2'd0: t = {3'd0, i};
			2'd1: t = 9'd5 * {3'd0, i} + 9'd1;
			2'd2: t = 9'd3 * {3'd0, i} + 9'd5;
			default: t = 9'd7 * {3'd0, i};
		endcase
		return t[3:0];
	endfunction

	// little-endian word to byte order
	function automatic logic [31:0] bswap(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage
`default_nettype wire

@@ hdl/md5he_in_if.sv @@
`default_nettype none
interface md5he_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/md5he_out_if.sv @@
`default_nettype none
interface md5he_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_high;
	logic [63:0] digest_low;

	modport source (output valid, output digest_high, output digest_low, input ready);
	modport sink (input valid, input digest_high, input digest_low, output ready);
endinterface
`default_nettype wire

@@ hdl/md5he_front.sv @@
`default_nettype none
module md5he_front
	import md5he_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	md5he_in_if.sink    msg,
	output logic        item_valid,
	output item_t       item,
	input  wire         item_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	item_t         queue_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign msg.ready  = (count_q != FULL);
	assign item_valid = (count_q != '0);
	assign item       = queue_q[rd_ptr_q];
	assign push       = msg.valid && msg.ready;
	assign pop        = item_valid && item_ready;

	// queue storage: a finish item is tagged by its kind bit
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: msg.kind, data_byte: msg.data_byte};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ hdl/md5he_back.sv @@
`default_nettype none
module md5he_back
	import md5he_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	input  item_t       item,
	output logic        item_ready,
	md5he_out_if.source digest
);

	state_t      state_q, state_d;
	pad_t        pad_q;
	logic        two_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [63:0] bitlen_q;
	logic [31:0] ch_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  cnt_q;
	logic [31:0] mem_q [16];
	logic [31:0] rd_q;
	logic [3:0]  wi_q;
	logic [3:0]  raddr;
	logic        out_valid_q;
	logic [63:0] out_hi_q, out_lo_q;
	logic [5:0]  pos;
	logic        take, emit_ok;
	logic [31:0] w_eff, f, t, rot;

	assign pos        = bitlen_q[8:3];
	assign item_ready = (state_q == ST_IDLE);
	assign take       = item_valid && item_ready;
	assign emit_ok    = !out_valid_q || digest.ready;

	assign digest.valid       = out_valid_q;
	assign digest.digest_high = out_hi_q;
	assign digest.digest_low  = out_lo_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && (item.kind == KIND_FINISH || pos == LAST_POS)) state_d = ST_LOAD;
			end
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == LAST_POS) state_d = ST_ADD;
			ST_ADD: begin
				if (pad_q == PAD_NONE) state_d = ST_IDLE;
				else if (pad_q == PAD_FIRST && two_q) state_d = ST_LOAD;
				else state_d = ST_EMIT;
			end
			ST_EMIT:  if (emit_ok) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// block buffer: byte writes, registered word reads
	assign raddr = (state_q == ST_ROUND) ? word_sel(cnt_q + 6'd1) : 4'd0;

	always_ff @(posedge clk) begin
		if (take && item.kind == KIND_BYTE) begin
			mem_q[pos[5:2]][8*pos[1:0] +: 8] <= item.data_byte;
		end
		rd_q <= mem_q[raddr];
		wi_q <= raddr;
	end

	// padding applied on the read side
	always_comb begin
		logic [5:0] idx;
		logic [7:0] bv;
		w_eff = rd_q;
		for (int j = 0; j < 4; j++) begin
			idx = {wi_q, 2'(j)};
			bv  = rd_q[8*j +: 8];
			if (pad_q == PAD_FIRST) begin
				if (idx == fill_q) bv = PAD_BYTE;
				else if (idx > fill_q) bv = 8'h00;
				if (!two_q && idx >= LEN_POS) bv = len_q[8*idx[2:0] +: 8];
			end else if (pad_q == PAD_SECOND) begin
				bv = (idx >= LEN_POS) ? len_q[8*idx[2:0] +: 8] : 8'h00;
			end
			w_eff[8*j +: 8] = bv;
		end
	end

	// one MD5 round
	always_comb begin
		case (cnt_q[5:4])
			2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
			2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t   = a_q + f + round_k(cnt_q) + w_eff;
		rot = (t << rot_amt(cnt_q)) | (t >> (6'd32 - {1'b0, rot_amt(cnt_q)}));
	end

	// working registers of the round unit
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			a_q <= ch_q[0];
			b_q <= ch_q[1];
			c_q <= ch_q[2];
			d_q <= ch_q[3];
		end else if (state_q == ST_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
		if (take && item.kind == KIND_FINISH) begin
			fill_q <= pos;
			len_q  <= bitlen_q;
			two_q  <= (pos >= LEN_POS);
		end
	end

	// chaining words, length counter, pad phase, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q[0]     <= IV_A;
			ch_q[1]     <= IV_B;
			ch_q[2]     <= IV_C;
			ch_q[3]     <= IV_D;
			bitlen_q    <= '0;
			pad_q       <= PAD_NONE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_hi_q    <= '0;
			out_lo_q    <= '0;
		end else begin
			if (out_valid_q && digest.ready && state_q != ST_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (item.kind == KIND_BYTE) bitlen_q <= bitlen_q + 64'd8;
						else pad_q <= PAD_FIRST;
					end
				end
				ST_LOAD:  cnt_q <= '0;
				ST_ROUND: cnt_q <= cnt_q + 6'd1;
				ST_ADD: begin
					ch_q[0] <= ch_q[0] + a_q;
					ch_q[1] <= ch_q[1] + b_q;
					ch_q[2] <= ch_q[2] + c_q;
					ch_q[3] <= ch_q[3] + d_q;
					if (pad_q == PAD_FIRST && two_q) pad_q <= PAD_SECOND;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						out_hi_q    <= {bswap(ch_q[0]), bswap(ch_q[1])};
						out_lo_q    <= {bswap(ch_q[2]), bswap(ch_q[3])};
						ch_q[0]     <= IV_A;
						ch_q[1]     <= IV_B;
						ch_q[2]     <= IV_C;
						ch_q[3]     <= IV_D;
						bitlen_q    <= '0;
						pad_q       <= PAD_NONE;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/md5_hash_engine_core.sv @@
// MD5 digest engine over a byte stream. A byte item is stored in the block buffer;
// the 64th byte of a block starts a compression (a load step, 64 rounds on
// a single round unit, one chaining add) during which the input queue of
// QUEUE_DEPTH items keeps accepting until it is full. A finish item pads the
// message and compresses once, or twice when 56 or more bytes of the block
// are filled, then loads the digest into the output register. After the
// digest the engine is back at the initial vector.
`default_nettype none
module md5_hash_engine_core
	import md5he_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	md5he_in_if.sink    msg,
	md5he_out_if.source digest
);

	logic  item_valid, item_ready;
	item_t item;

	md5he_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	md5he_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.digest     (digest)
	);

endmodule
`default_nettype wire

@@ tb/sv/md5_digest_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module md5_digest_checker
	import md5he_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        msg_valid,
	input  wire        msg_ready,
	input  wire        msg_kind,
	input  wire [7:0]  msg_byte,
	input  wire        dig_valid,
	input  wire        dig_ready,
	input  wire [63:0] dig_high,
	input  wire [63:0] dig_low,
	output int         fail_count,
	output int         pending,
	output int         digests_seen,
	output int         bytes_seen
);

	localparam logic [31:0] MIX_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
		6, 10, 15, 21};

	logic [31:0]  chain [4];
	logic [7:0]   blk [64];
	logic [63:0]  nbits;
	logic [127:0] want_q [$];

	function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	// one 64-round compression of blk into chain
	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = d ^ (b & (c ^ d)); g = i;
			end else if (i < 32) begin
				f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3 * i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7 * i) % 16;
			end
			t = a + f + MIX_K[i] + w[g];
			a = d; d = c; c = b;
			b = b + rotl(t, SHIFTS[(i / 16) * 4 + (i % 4)]);
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endtask

	task automatic restart();
		chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
		nbits = '0;
	endtask

	function automatic logic [63:0] le_pack(input logic [31:0] w0, input logic [31:0] w1);
		return {w0[7:0], w0[15:8], w0[23:16], w0[31:24],
			w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
	endfunction

	// apply one accepted item to the model state
	task automatic absorb(input logic knd, input logic [7:0] byt);
		int pos;
		pos = int'(nbits[8:3]);
		if (knd == KIND_BYTE) begin
			blk[pos] = byt;
			nbits += 64'd8;
			if (pos == 63) compress();
		end else begin
			blk[pos] = PAD_BYTE;
			for (int i = pos + 1; i < 64; i++) blk[i] = '0;
			if (pos >= 56) begin
				compress();
				for (int i = 0; i < 56; i++) blk[i] = '0;
			end
			for (int i = 0; i < 8; i++) blk[56+i] = nbits[8*i +: 8];
			compress();
			want_q.push_back({le_pack(chain[0], chain[1]), le_pack(chain[2], chain[3])});
			restart();
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0; digests_seen = 0; bytes_seen = 0; pending = 0;
		restart();
	end

	always @(posedge clk) begin
		logic [127:0] exp;
		if (arst_n) begin
			if (msg_valid && msg_ready) begin
				if (msg_kind == KIND_BYTE) bytes_seen++;
				absorb(msg_kind, msg_byte);
			end
			if (dig_valid && dig_ready) begin
				digests_seen++;
				if (want_q.size() == 0) begin
					report("unexpected digest", dig_high, dig_low);
				end else begin
					exp = want_q.pop_front();
					if (dig_high !== exp[127:64]) report("digest_high", dig_high, exp[127:64]);
					if (dig_low !== exp[63:0]) report("digest_low", dig_low, exp[63:0]);
				end
			end
			pending = want_q.size();
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_md5_hash_engine_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_md5_hash_engine_core;
	import md5he_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic calm;
	logic hold_off;
	int   cycles;
	int   fail_count, pending, digests_seen, bytes_seen;
	int   msgs_sent;

	md5he_in_if  msg ();
	md5he_out_if digest ();

	md5_hash_engine_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	md5_digest_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg.valid),
		.msg_ready    (msg.ready),
		.msg_kind     (msg.kind),
		.msg_byte     (msg.data_byte),
		.dig_valid    (digest.valid),
		.dig_ready    (digest.ready),
		.dig_high     (digest.digest_high),
		.dig_low      (digest.digest_low),
		.fail_count   (fail_count),
		.pending      (pending),
		.digests_seen (digests_seen),
		.bytes_seen   (bytes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off
	initial begin
		digest.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			digest.ready <= !hold_off && (calm || $urandom_range(99) >= 10);
		end
	end

	// send one item, idling at random first
	task automatic send(input logic knd, input logic [7:0] byt);
		if (!calm && $urandom_range(99) < 10) begin
			msg.valid <= 1'b0;
			@(negedge clk);
		end
		msg.valid     <= 1'b1;
		msg.kind      <= knd;
		msg.data_byte <= byt;
		@(posedge clk);
		while (!msg.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(input int len, input int fill_mode);
		for (int i = 0; i < len; i++)
			case (fill_mode)
				0: send(KIND_BYTE, 8'h00);
				1: send(KIND_BYTE, 8'hff);
				default: send(KIND_BYTE, 8'($urandom));
			endcase
		send(KIND_FINISH, 8'($urandom));
		msgs_sent++;
	endtask

	task automatic pick_len(output int len);
		case ($urandom_range(9))
			0: len = $urandom_range(55, 57);
			1: len = $urandom_range(62, 66);
			2: len = $urandom_range(119, 129);
			default: len = $urandom_range(0, 20);
		endcase
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		calm = 1'b0;
		hold_off = 1'b0;
		msgs_sent = 0;
		msg.valid = 1'b0;
		msg.kind = KIND_BYTE;
		msg.data_byte = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty message, finish right after finish, byte extremes
		send_message(0, 2);
		send_message(0, 2);
		send_message(1, 0);
		send_message(1, 1);
		send_message(3, 2);
		send(KIND_BYTE, 8'h55);
		send(KIND_BYTE, 8'haa);
		send(KIND_FINISH, 8'hff);
		msgs_sent++;

		// padding boundaries and full blocks
		send_message(55, 2);
		send_message(56, 2);
		send_message(63, 1);
		send_message(64, 0);

		// receiver holds off while sender keeps offering items
		fork
			begin
				hold_off <= 1'b1;
				repeat (800) @(negedge clk);
				hold_off <= 1'b0;
			end
			for (int m = 0; m < 4; m++) send_message($urandom_range(0, 6), 2);
		join

		// random messages, with a stretch of no idling
		while (bytes_seen < 1100) begin
			calm = (msgs_sent % 40) >= 30;
			pick_len(len);
			send_message(len, $urandom_range(9) == 0 ? 1 : 2);
		end
		calm = 1'b0;
		msg.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		$display("covered %0d message bytes in %0d messages, %0d digests checked",
			bytes_seen, msgs_sent, digests_seen);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
